[rtl/bpid_pkg.sv]
package bpid_pkg;

   localparam int NUM_SPECIES = 4;
   localparam int CFG_W       = 16;
   localparam int SIGMA_W     = 14;
   localparam int SQ_W        = 27;
   localparam int CHI_W       = 28;
   localparam int LIK_W       = 17;
   localparam int PRIOR_W     = 16;
   localparam int WGT_W       = LIK_W + PRIOR_W;
   localparam int SUM_W       = WGT_W + $clog2(NUM_SPECIES);
   localparam int PROB_W      = 16;
   localparam int EXP_SHIFT   = 20;
   localparam int CSR_IDX_W   = 3;

   typedef logic signed [SIGMA_W-1:0] sigma_type;
   typedef logic [NUM_SPECIES-1:0][WGT_W-1:0] wgt_vec_type;
   typedef logic [NUM_SPECIES-1:0][PROB_W-1:0] prob_vec_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PT_LOWER       = 3'd0,
      CSR_PT_UPPER       = 3'd1,
      CSR_ETA_LOWER      = 3'd2,
      CSR_ETA_UPPER      = 3'd3,
      CSR_PRIOR_PION     = 3'd4,
      CSR_PRIOR_KAON     = 3'd5,
      CSR_PRIOR_PROTON   = 3'd6,
      CSR_PRIOR_ELECTRON = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0]                      pt_lower;
      logic [CFG_W-1:0]                      pt_upper;
      logic signed [CFG_W-1:0]               eta_lower;
      logic signed [CFG_W-1:0]               eta_upper;
      logic [NUM_SPECIES-1:0][PRIOR_W-1:0]   prior;
   } cfg_type;

endpackage

[rtl/bpid_front.sv]
module bpid_front #(
   parameter int EXP_TABLE_ENTRIES = 256
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  bpid_pkg::cfg_type                            cfg,
   input  logic                                         up_valid,
   output logic                                         up_ready,
   input  logic [bpid_pkg::CFG_W-1:0]                   track_pt,
   input  logic signed [bpid_pkg::CFG_W-1:0]            track_eta,
   input  bpid_pkg::sigma_type [bpid_pkg::NUM_SPECIES-1:0] eloss_sigma,
   input  bpid_pkg::sigma_type [bpid_pkg::NUM_SPECIES-1:0] flight_sigma,
   input  logic                                         eloss_present,
   input  logic                                         flight_present,
   output logic                                         down_valid,
   input  logic                                         down_ready,
   output logic [bpid_pkg::NUM_SPECIES-1:0][bpid_pkg::LIK_W-1:0] lik
);
   import bpid_pkg::*;

   localparam int IDX_W   = (EXP_TABLE_ENTRIES > 1) ? $clog2(EXP_TABLE_ENTRIES) : 1;
   localparam int SCALE_W = CHI_W - 1 + $clog2(EXP_TABLE_ENTRIES + 1);

   typedef logic [LIK_W-1:0] lik_table_type [EXP_TABLE_ENTRIES];

   // Entry k holds exp(-k*step) rounded to Q1.16; built at elaboration.
   function automatic lik_table_type build_table();
      logic [63:0] d;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      logic [63:0] base;
      logic [63:0] e;
      lik_table_type t;
      d    = (64'd16 << 30) / EXP_TABLE_ENTRIES;
      term = 64'd1 << 30;
      pos  = 64'd1 << 30;
      neg  = 64'd0;
      for (int n = 1; n <= 24; n++) begin
         term = ((term * d) >> 30) / 64'(n);
         if (n % 2 == 1) neg = neg + term;
         else pos = pos + term;
      end
      base = (pos > neg) ? pos - neg : 64'd0;
      e    = 64'd1 << 30;
      for (int k = 0; k < EXP_TABLE_ENTRIES; k++) begin
         if (k > 0) e = (e * base + (64'd1 << 29)) >> 30;
         t[k] = LIK_W'((e + 64'd8192) >> 14);
      end
      return t;
   endfunction

   localparam lik_table_type LIK_TABLE = build_table();

   logic v1_ff, v2_ff, v3_ff;
   logic ld1, ld2, ld3;
   logic hit;
   logic [NUM_SPECIES-1:0][SQ_W-1:0] sqe_in, sqe_ff, sqf_in, sqf_ff;
   logic [NUM_SPECIES-1:0][IDX_W-1:0] idx_in, idx_ff;
   logic [NUM_SPECIES-1:0] rng_in, rng_ff;
   logic [NUM_SPECIES-1:0][LIK_W-1:0] lik_ff;

   assign ld3      = !v3_ff || down_ready;
   assign ld2      = !v2_ff || ld3;
   assign ld1      = !v1_ff || ld2;
   assign up_ready = ld1;

   assign hit = (track_pt >= cfg.pt_lower) && (track_pt <= cfg.pt_upper) &&
                (track_eta >= cfg.eta_lower) && (track_eta <= cfg.eta_upper);

   always_comb begin
      logic signed [2*SIGMA_W-1:0] pe;
      logic signed [2*SIGMA_W-1:0] pf;
      logic [CHI_W-1:0] chi;
      logic [SCALE_W-1:0] scaled;
      for (int i = 0; i < NUM_SPECIES; i++) begin
         pe = $signed(eloss_sigma[i]) * $signed(eloss_sigma[i]);
         pf = $signed(flight_sigma[i]) * $signed(flight_sigma[i]);
         sqe_in[i] = eloss_present  ? pe[SQ_W-1:0] : '0;
         sqf_in[i] = flight_present ? pf[SQ_W-1:0] : '0;
         chi = CHI_W'(sqe_ff[i]) + CHI_W'(sqf_ff[i]);
         scaled = SCALE_W'(chi[CHI_W-1:1]) * SCALE_W'(EXP_TABLE_ENTRIES);
         scaled = scaled >> EXP_SHIFT;
         rng_in[i] = scaled < SCALE_W'(EXP_TABLE_ENTRIES);
         idx_in[i] = scaled[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ld1) v1_ff <= up_valid && hit;
         if (ld2) v2_ff <= v1_ff;
         if (ld3) v3_ff <= v2_ff;
      end
      if (ld1) begin
         sqe_ff <= sqe_in;
         sqf_ff <= sqf_in;
      end
      if (ld2) begin
         idx_ff <= idx_in;
         rng_ff <= rng_in;
      end
      if (ld3) begin
         for (int i = 0; i < NUM_SPECIES; i++)
            lik_ff[i] <= rng_ff[i] ? LIK_TABLE[idx_ff[i]] : '0;
      end
   end

   assign down_valid = v3_ff;
   assign lik        = lik_ff;

endmodule

[rtl/bpid_weight.sv]
module bpid_weight (
   input  logic                          clock,
   input  logic                          reset,
   input  bpid_pkg::cfg_type             cfg,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  logic [bpid_pkg::NUM_SPECIES-1:0][bpid_pkg::LIK_W-1:0] lik,
   output logic                          down_valid,
   input  logic                          down_ready,
   output bpid_pkg::wgt_vec_type         wgt,
   output logic [bpid_pkg::SUM_W-1:0]    wsum
);
   import bpid_pkg::*;

   logic v1_ff, v2_ff, ld1, ld2;
   wgt_vec_type w1_ff, w2_ff;
   logic [SUM_W-1:0] sum_in, sum_ff;

   assign ld2      = !v2_ff || down_ready;
   assign ld1      = !v1_ff || ld2;
   assign up_ready = ld1;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NUM_SPECIES; i++) sum_in = sum_in + SUM_W'(w1_ff[i]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (ld1) v1_ff <= up_valid;
         if (ld2) v2_ff <= v1_ff;
      end
      if (ld1) begin
         for (int i = 0; i < NUM_SPECIES; i++)
            w1_ff[i] <= WGT_W'(lik[i]) * WGT_W'(cfg.prior[i]);
      end
      if (ld2) begin
         w2_ff  <= w1_ff;
         sum_ff <= sum_in;
      end
   end

   assign down_valid = v2_ff;
   assign wgt        = w2_ff;
   assign wsum       = sum_ff;

endmodule

[rtl/bpid_divider.sv]
module bpid_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        up_valid,
   output logic                        up_ready,
   input  bpid_pkg::wgt_vec_type       wgt,
   input  logic [bpid_pkg::SUM_W-1:0]  wsum,
   output logic                        down_valid,
   input  logic                        down_ready,
   output bpid_pkg::prob_vec_type      prob,
   output logic                        no_support
);
   import bpid_pkg::*;

   localparam int QB   = PROB_W + 1;
   localparam int NSTG = QB + 1;
   localparam int RW   = SUM_W + 1;

   logic             v_ff   [NSTG];
   logic             ld     [NSTG];
   logic [RW-1:0]    rem_ff [QB][NUM_SPECIES];
   logic [QB-1:0]    quo_ff [QB][NUM_SPECIES];
   logic [SUM_W-1:0] den_ff [QB];
   logic             zero_ff[QB];
   prob_vec_type     prob_ff;
   logic             nos_ff;

   always_comb begin
      ld[NSTG-1] = !v_ff[NSTG-1] || down_ready;
      for (int s = NSTG - 2; s >= 0; s--) ld[s] = !v_ff[s] || ld[s+1];
   end
   assign up_ready = ld[0];

   // One quotient bit per stage, most significant first.
   for (genvar s = 0; s < QB; s++) begin : g_stage
      localparam int PREV = (s > 0) ? s - 1 : 0;

      logic [RW-1:0]    rem_src [NUM_SPECIES];
      logic [QB-1:0]    quo_src [NUM_SPECIES];
      logic [RW-1:0]    rem_nxt [NUM_SPECIES];
      logic [QB-1:0]    quo_nxt [NUM_SPECIES];
      logic [SUM_W-1:0] den_src;
      logic             zero_src;
      logic             v_src;

      always_comb begin
         logic ge;
         if (s == 0) begin
            den_src  = wsum;
            zero_src = (wsum == '0);
            v_src    = up_valid;
         end else begin
            den_src  = den_ff[PREV];
            zero_src = zero_ff[PREV];
            v_src    = v_ff[PREV];
         end
         for (int i = 0; i < NUM_SPECIES; i++) begin
            if (s == 0) begin
               rem_src[i] = RW'(wgt[i]);
               quo_src[i] = '0;
            end else begin
               rem_src[i] = rem_ff[PREV][i] << 1;
               quo_src[i] = quo_ff[PREV][i];
            end
            ge = rem_src[i] >= RW'(den_src);
            rem_nxt[i] = ge ? rem_src[i] - RW'(den_src) : rem_src[i];
            quo_nxt[i] = {quo_src[i][QB-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) v_ff[s] <= 1'b0;
         else if (ld[s]) v_ff[s] <= v_src;
         if (ld[s]) begin
            den_ff[s]  <= den_src;
            zero_ff[s] <= zero_src;
            for (int i = 0; i < NUM_SPECIES; i++) begin
               rem_ff[s][i] <= rem_nxt[i];
               quo_ff[s][i] <= quo_nxt[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff[NSTG-1] <= 1'b0;
      else if (ld[NSTG-1]) v_ff[NSTG-1] <= v_ff[QB-1];
      if (ld[NSTG-1]) begin
         nos_ff <= zero_ff[QB-1];
         for (int i = 0; i < NUM_SPECIES; i++) begin
            if (zero_ff[QB-1]) prob_ff[i] <= '0;
            else if (quo_ff[QB-1][i][QB-1]) prob_ff[i] <= '1;
            else prob_ff[i] <= quo_ff[QB-1][i][PROB_W-1:0];
         end
      end
   end

   assign down_valid = v_ff[NSTG-1];
   assign prob       = prob_ff;
   assign no_support = nos_ff;

endmodule

[rtl/bayesian_particle_id.sv]
// Bayesian particle identification for four species (pion, kaon, proton,
// electron). Each request beat carries one track; tracks outside the pt and
// eta windows are dropped and give no response beat. For the rest, the
// block squares the n-sigma values of the detectors flagged present, looks
// up exp(-chi2/2) in a constant table, weights it by the programmed prior
// and normalizes over the species with a restoring divider of one quotient
// bit per stage. The pipeline takes one track per clock unless the response
// side stalls, and a response beat passes through three front stages
// (squares, table index, table read), two for weight and sum, seventeen
// divider stages and the output register. A stall holds only the occupied
// stages, so bubbles are squeezed out. Program the CSRs only while no track
// is in flight.
module bayesian_particle_id #(
   parameter int EXP_TABLE_ENTRIES = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [bpid_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bpid_pkg::CFG_W-1:0]       csr_data,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [15:0]                      req_track_pt,
   input  logic signed [15:0]               req_track_eta,
   input  logic signed [13:0]               req_eloss_sigma_pion,
   input  logic signed [13:0]               req_eloss_sigma_kaon,
   input  logic signed [13:0]               req_eloss_sigma_proton,
   input  logic signed [13:0]               req_eloss_sigma_electron,
   input  logic signed [13:0]               req_flight_sigma_pion,
   input  logic signed [13:0]               req_flight_sigma_kaon,
   input  logic signed [13:0]               req_flight_sigma_proton,
   input  logic signed [13:0]               req_flight_sigma_electron,
   input  logic                             req_eloss_present,
   input  logic                             req_flight_present,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [15:0]                      rsp_prob_pion,
   output logic [15:0]                      rsp_prob_kaon,
   output logic [15:0]                      rsp_prob_proton,
   output logic [15:0]                      rsp_prob_electron,
   output logic                             rsp_no_support
);
   import bpid_pkg::*;

   cfg_type cfg_ff;

   // CSR writes land directly; unknown indexes cannot occur at this width.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pt_lower  <= 16'd26;
         cfg_ff.pt_upper  <= 16'd5120;
         cfg_ff.eta_lower <= -16'sd6144;
         cfg_ff.eta_upper <= 16'sd6144;
         cfg_ff.prior[0]  <= 16'd32768;
         cfg_ff.prior[1]  <= 16'd6554;
         cfg_ff.prior[2]  <= 16'd3277;
         cfg_ff.prior[3]  <= 16'd1638;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_PT_LOWER:       cfg_ff.pt_lower  <= csr_data;
            CSR_PT_UPPER:       cfg_ff.pt_upper  <= csr_data;
            CSR_ETA_LOWER:      cfg_ff.eta_lower <= csr_data;
            CSR_ETA_UPPER:      cfg_ff.eta_upper <= csr_data;
            CSR_PRIOR_PION:     cfg_ff.prior[0]  <= csr_data;
            CSR_PRIOR_KAON:     cfg_ff.prior[1]  <= csr_data;
            CSR_PRIOR_PROTON:   cfg_ff.prior[2]  <= csr_data;
            CSR_PRIOR_ELECTRON: cfg_ff.prior[3]  <= csr_data;
            default: ;
         endcase
      end
   end

   sigma_type [NUM_SPECIES-1:0] eloss_vec, flight_vec;
   assign eloss_vec  = {req_eloss_sigma_electron, req_eloss_sigma_proton,
                        req_eloss_sigma_kaon, req_eloss_sigma_pion};
   assign flight_vec = {req_flight_sigma_electron, req_flight_sigma_proton,
                        req_flight_sigma_kaon, req_flight_sigma_pion};

   logic f_valid, f_ready, w_valid, w_ready;
   logic [NUM_SPECIES-1:0][LIK_W-1:0] lik;
   wgt_vec_type wgt;
   logic [SUM_W-1:0] wsum;
   prob_vec_type prob;

   bpid_front #(.EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .up_valid       (req_valid),
      .up_ready       (req_ready),
      .track_pt       (req_track_pt),
      .track_eta      (req_track_eta),
      .eloss_sigma    (eloss_vec),
      .flight_sigma   (flight_vec),
      .eloss_present  (req_eloss_present),
      .flight_present (req_flight_present),
      .down_valid     (f_valid),
      .down_ready     (f_ready),
      .lik            (lik)
   );

   bpid_weight u_weight (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .up_valid   (f_valid),
      .up_ready   (f_ready),
      .lik        (lik),
      .down_valid (w_valid),
      .down_ready (w_ready),
      .wgt        (wgt),
      .wsum       (wsum)
   );

   bpid_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (w_valid),
      .up_ready   (w_ready),
      .wgt        (wgt),
      .wsum       (wsum),
      .down_valid (rsp_valid),
      .down_ready (rsp_ready),
      .prob       (prob),
      .no_support (rsp_no_support)
   );

   assign rsp_prob_pion     = prob[0];
   assign rsp_prob_kaon     = prob[1];
   assign rsp_prob_proton   = prob[2];
   assign rsp_prob_electron = prob[3];

   // A response with no support must carry all-zero probabilities.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_support |-> (rsp_prob_pion == '0) && (rsp_prob_kaon == '0) &&
         (rsp_prob_proton == '0) && (rsp_prob_electron == '0))
      else $error("no_support beat with nonzero probability");

   // With the output side free, the whole pipeline can move, so req_ready is high.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("pipeline stalled while the output was free");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response beat right after reset");

endmodule

[sim/bayesian_particle_id_test.sv]
module bayesian_particle_id_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bpid_pkg::*;

   // Four species in the fixed order pion, kaon, proton, electron.
   localparam int SPECIES       = 4;
   localparam int TABLE_ENTRIES = 256;
   localparam int TABLE_RANGE   = 16;
   localparam int STALL_LIMIT   = 20000;
   localparam int DRAIN_CYCLES  = 60;
   localparam int LONG_HOLD     = 400;

   typedef struct {
      logic [15:0]        pt;
      logic signed [15:0] eta;
      sigma_type          eloss [SPECIES];
      sigma_type          flight [SPECIES];
      bit                 eloss_on;
      bit                 flight_on;
   } trk_rec_type;

   typedef struct {
      logic [15:0] prob [SPECIES];
      bit          no_support;
   } pid_type;

   // A directed row either carries a hand-written answer (typed) or leaves the
   // answer to the predictor.
   typedef struct {
      trk_rec_type track;
      bit          typed;
      bit          typed_kept;
      pid_type     typed_pid;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_data  = '0;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [15:0]        req_track_pt = '0;
   logic signed [15:0] req_track_eta = '0;
   sigma_type          req_eloss [SPECIES] = '{default: '0};
   sigma_type          req_flight [SPECIES] = '{default: '0};
   logic               req_eloss_present = 1'b0;
   logic               req_flight_present = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_prob [SPECIES];
   logic        rsp_no_support;

   bayesian_particle_id dut (
      .clock                    (clock),
      .reset                    (reset),
      .csr_wr_en                (csr_wr_en),
      .csr_index                (csr_index),
      .csr_data                 (csr_data),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_track_pt             (req_track_pt),
      .req_track_eta            (req_track_eta),
      .req_eloss_sigma_pion     (req_eloss[0]),
      .req_eloss_sigma_kaon     (req_eloss[1]),
      .req_eloss_sigma_proton   (req_eloss[2]),
      .req_eloss_sigma_electron (req_eloss[3]),
      .req_flight_sigma_pion    (req_flight[0]),
      .req_flight_sigma_kaon    (req_flight[1]),
      .req_flight_sigma_proton  (req_flight[2]),
      .req_flight_sigma_electron(req_flight[3]),
      .req_eloss_present        (req_eloss_present),
      .req_flight_present       (req_flight_present),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_prob_pion            (rsp_prob[0]),
      .rsp_prob_kaon            (rsp_prob[1]),
      .rsp_prob_proton          (rsp_prob[2]),
      .rsp_prob_electron        (rsp_prob[3]),
      .rsp_no_support           (rsp_no_support)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the CSRs and of the exponential table, kept by the
   // testbench so it can predict every response beat on its own.
   cfg_type     shadow_cfg;
   logic [31:0] exp_q30 [TABLE_ENTRIES];

   pid_type pending_pids [$];
   int      mismatches = 0;
   bit      no_idle = 1'b0;
   bit      hold_request = 1'b0;

   // Builds exp(-k*step) in Q2.30. The base comes from a truncated Taylor
   // series and each entry is the previous one times the base, rounded.
   task automatic build_exp_table();
      logic [63:0] step_q30, term, pos, neg, base;
      step_q30 = (64'(TABLE_RANGE) << 30) / TABLE_ENTRIES;
      term = 64'd1 << 30;
      pos  = 64'd1 << 30;
      neg  = '0;
      for (int n = 1; n <= 24; n++) begin
         term = ((term * step_q30) >> 30) / n;
         if (n % 2 == 1) neg += term;
         else pos += term;
      end
      base = (pos > neg) ? pos - neg : '0;
      exp_q30[0] = 32'd1 << 30;
      for (int k = 1; k < TABLE_ENTRIES; k++)
         exp_q30[k] = 32'((64'(exp_q30[k-1]) * base + (64'd1 << 29)) >> 30);
   endtask

   // Returns 0 when the track falls outside a window and no beat comes out.
   function automatic bit predict_pid(trk_rec_type t, output pid_type pid);
      logic [63:0] weight [SPECIES];
      logic [63:0] total, chi2, index, lik, quot;
      total = '0;
      pid.no_support = 1'b0;
      for (int i = 0; i < SPECIES; i++) pid.prob[i] = '0;
      if (t.pt < shadow_cfg.pt_lower || t.pt > shadow_cfg.pt_upper) return 1'b0;
      if (t.eta < shadow_cfg.eta_lower || t.eta > shadow_cfg.eta_upper) return 1'b0;
      for (int i = 0; i < SPECIES; i++) begin
         chi2 = '0;
         if (t.eloss_on) chi2 += 64'(int'(t.eloss[i]) * int'(t.eloss[i]));
         if (t.flight_on) chi2 += 64'(int'(t.flight[i]) * int'(t.flight[i]));
         index = ((chi2 >> 1) * TABLE_ENTRIES) / (64'(TABLE_RANGE) << 16);
         lik = (index < TABLE_ENTRIES) ? (64'(exp_q30[index]) + (64'd1 << 13)) >> 14 : '0;
         weight[i] = lik * 64'(shadow_cfg.prior[SPECIES-1-i]);
         total += weight[i];
      end
      for (int i = 0; i < SPECIES; i++) begin
         if (total != 0) begin
            quot = (weight[i] << 16) / total;
            pid.prob[i] = (quot > 64'd65535) ? 16'hFFFF : quot[15:0];
         end
      end
      pid.no_support = (total == 0);
      return 1'b1;
   endfunction

   // The shadow copy keeps the priors as a packed array with pion in the top
   // slot, matching the order in which they are listed.
   task automatic csr_write(csr_index_type idx, logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      case (idx)
         CSR_PT_LOWER:       shadow_cfg.pt_lower  = value;
         CSR_PT_UPPER:       shadow_cfg.pt_upper  = value;
         CSR_ETA_LOWER:      shadow_cfg.eta_lower = value;
         CSR_ETA_UPPER:      shadow_cfg.eta_upper = value;
         CSR_PRIOR_PION:     shadow_cfg.prior[3]  = value;
         CSR_PRIOR_KAON:     shadow_cfg.prior[2]  = value;
         CSR_PRIOR_PROTON:   shadow_cfg.prior[1]  = value;
         CSR_PRIOR_ELECTRON: shadow_cfg.prior[0]  = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic program_all(logic [15:0] pt_lo, logic [15:0] pt_hi,
                              logic [15:0] eta_lo, logic [15:0] eta_hi,
                              logic [15:0] pr_pi, logic [15:0] pr_k,
                              logic [15:0] pr_p, logic [15:0] pr_e);
      csr_write(CSR_PT_LOWER, pt_lo);
      csr_write(CSR_PT_UPPER, pt_hi);
      csr_write(CSR_ETA_LOWER, eta_lo);
      csr_write(CSR_ETA_UPPER, eta_hi);
      csr_write(CSR_PRIOR_PION, pr_pi);
      csr_write(CSR_PRIOR_KAON, pr_k);
      csr_write(CSR_PRIOR_PROTON, pr_p);
      csr_write(CSR_PRIOR_ELECTRON, pr_e);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Wait until every expected beat has come back, then let dropped tracks
   // that may still sit in the front stages run out before touching CSRs.
   task automatic drain();
      while (pending_pids.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Presents one track and holds it until the beat is taken. Valid drops
   // only when a gap follows, so it is never lowered and raised in one step.
   task automatic send_track(trk_rec_type t, bit typed, bit typed_kept, pid_type typed_pid);
      pid_type pid;
      bit kept;
      int gap;
      req_valid          <= 1'b1;
      req_track_pt       <= t.pt;
      req_track_eta      <= t.eta;
      req_eloss          <= t.eloss;
      req_flight         <= t.flight;
      req_eloss_present  <= t.eloss_on;
      req_flight_present <= t.flight_on;
      do @(posedge clock); while (!req_ready);
      kept = predict_pid(t, pid);
      if (typed) begin
         kept = typed_kept;
         pid  = typed_pid;
      end
      if (kept) pending_pids.push_back(pid);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic int pick_between(int lo, int hi);
      if (lo > hi) return $urandom_range(0, 65535) - ((lo < 0) ? 32768 : 0);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // Mostly tracks that land inside the windows with n-sigmas small enough to
   // reach the live part of the table; the rest is unrestricted noise.
   function automatic trk_rec_type random_track();
      trk_rec_type t;
      int r;
      r = $urandom_range(0, 99);
      t.pt  = (r < 85) ? 16'(pick_between(shadow_cfg.pt_lower, shadow_cfg.pt_upper))
                       : 16'($urandom);
      t.eta = (r < 85) ? 16'(pick_between(shadow_cfg.eta_lower, shadow_cfg.eta_upper))
                       : 16'($urandom);
      for (int i = 0; i < SPECIES; i++) begin
         r = $urandom_range(0, 99);
         t.eloss[i]  = (r < 70) ? sigma_type'($urandom_range(0, 2047) - 1024)
                                : sigma_type'($urandom);
         r = $urandom_range(0, 99);
         t.flight[i] = (r < 70) ? sigma_type'($urandom_range(0, 2047) - 1024)
                                : sigma_type'($urandom);
      end
      t.eloss_on  = $urandom_range(0, 3) != 0;
      t.flight_on = $urandom_range(0, 3) != 0;
      return t;
   endfunction

   function automatic trk_rec_type plain_track(logic [15:0] pt, logic signed [15:0] eta,
                                               int sig, bit e_on, bit f_on);
      trk_rec_type t;
      t.pt = pt;
      t.eta = eta;
      for (int i = 0; i < SPECIES; i++) begin
         t.eloss[i]  = sigma_type'(sig);
         t.flight[i] = sigma_type'(sig);
      end
      t.eloss_on  = e_on;
      t.flight_on = f_on;
      return t;
   endfunction

   task automatic random_phase(int count);
      pid_type unused;
      for (int n = 0; n < count; n++) send_track(random_track(), 1'b0, 1'b0, unused);
   endtask

   // Response side: checks each beat against the oldest expectation and then
   // picks the next value of ready. A long hold, when requested, is counted
   // here in cycles while the sender keeps offering tracks.
   int hold_left = 0;
   always @(posedge clock) begin
      pid_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pids.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat at %0t", $realtime);
         end else begin
            want = pending_pids.pop_front();
            for (int i = 0; i < SPECIES; i++) begin
               if (rsp_prob[i] !== want.prob[i]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("species %0d probability: expected %0d, got %0d",
                              i, want.prob[i], rsp_prob[i]);
               end
            end
            if (rsp_no_support !== want.no_support) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("no_support: expected %0b, got %0b", want.no_support, rsp_no_support);
            end
         end
      end
      if (hold_request && hold_left == 0) hold_left = LONG_HOLD;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (no_idle) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= (pick_gap() == 0);
      end
   end

   // Watchdog on cycles without any accepted beat on either channel.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   row_type rows [$];

   initial begin
      row_type row;
      pid_type zero_support;
      int end_wait;

      build_exp_table();
      shadow_cfg.pt_lower  = 16'd26;
      shadow_cfg.pt_upper  = 16'd5120;
      shadow_cfg.eta_lower = -16'sd6144;
      shadow_cfg.eta_upper = 16'sd6144;
      shadow_cfg.prior     = {16'd32768, 16'd6554, 16'd3277, 16'd1638};

      for (int i = 0; i < SPECIES; i++) zero_support.prob[i] = '0;
      zero_support.no_support = 1'b1;

      // Directed rows, run under the reset values of the CSRs. Window edges,
      // the extremes of pt and eta, missing detectors, the table edge and the
      // zero-sum case.
      row.typed = 1'b1; row.typed_kept = 1'b0; row.typed_pid = zero_support;
      row.track = plain_track(16'd25, 16'sd0, 0, 1, 1);       rows.push_back(row);
      row.track = plain_track(16'd5121, 16'sd0, 0, 1, 1);     rows.push_back(row);
      row.track = plain_track(16'd0, 16'sd0, 0, 1, 1);        rows.push_back(row);
      row.track = plain_track(16'hFFFF, 16'sd0, 0, 1, 1);     rows.push_back(row);
      row.track = plain_track(16'd100, -16'sd6145, 0, 1, 1);  rows.push_back(row);
      row.track = plain_track(16'd100, 16'sd6145, 0, 1, 1);   rows.push_back(row);
      row.track = plain_track(16'd100, -16'sd32768, 0, 1, 1); rows.push_back(row);
      row.track = plain_track(16'd100, 16'sd32767, 0, 1, 1);  rows.push_back(row);
      // Every n-sigma at an extreme pushes every species off the table.
      row.typed_kept = 1'b1;
      row.track = plain_track(16'd100, 16'sd0, 8191, 1, 1);   rows.push_back(row);
      row.track = plain_track(16'd100, 16'sd0, -8192, 1, 0);  rows.push_back(row);
      row.track = plain_track(16'd100, 16'sd0, -8192, 0, 1);  rows.push_back(row);
      row.typed = 1'b0;
      row.track = plain_track(16'd26, 16'sd0, 100, 1, 1);     rows.push_back(row);
      row.track = plain_track(16'd5120, 16'sd0, -100, 1, 1);  rows.push_back(row);
      row.track = plain_track(16'd500, -16'sd6144, 300, 1, 0); rows.push_back(row);
      row.track = plain_track(16'd500, 16'sd6144, 300, 0, 1); rows.push_back(row);
      row.track = plain_track(16'd500, 16'sd0, 8191, 0, 0);   rows.push_back(row);
      row.track = plain_track(16'd500, 16'sd0, 0, 1, 1);      rows.push_back(row);
      // Pion n-sigma just inside and just past the last table entry.
      row.track = plain_track(16'd500, 16'sd0, 0, 1, 0);
      row.track.eloss[0] = 14'sd1448;                          rows.push_back(row);
      row.track.eloss[0] = 14'sd1449;                          rows.push_back(row);
      row.track.eloss[0] = -14'sd1449; row.track.eloss[3] = 14'sd1000; rows.push_back(row);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_track(rows[i].track, rows[i].typed, rows[i].typed_kept,
                                   rows[i].typed_pid);
      random_phase(150);

      // The sender pauses here until every expected beat has come back.
      req_valid <= 1'b0;
      drain();

      // Random windows and priors; the response side holds off long enough for
      // the pipeline to fill and stall the request side.
      program_all(16'($urandom_range(0, 300)), 16'($urandom_range(2000, 65535)),
                  16'(-$urandom_range(1000, 32768)), 16'($urandom_range(1000, 32767)),
                  16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                  16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)));
      hold_request = 1'b1;
      wait (hold_left != 0);
      hold_request = 1'b0;
      random_phase(200);
      req_valid <= 1'b0;
      drain();

      // Widest windows and a full-scale pion prior, with no idling on either side.
      no_idle = 1'b1;
      program_all(16'd0, 16'hFFFF, 16'h8000, 16'h7FFF,
                  16'hFFFF, 16'd32768, 16'd1, 16'd0);
      random_phase(180);
      req_valid <= 1'b0;
      drain();
      no_idle = 1'b0;

      // A single nonzero prior: the pion probability saturates at full scale.
      program_all(16'd0, 16'hFFFF, 16'h8000, 16'h7FFF,
                  16'd32768, 16'd0, 16'd0, 16'd0);
      random_phase(150);
      req_valid <= 1'b0;
      drain();

      // All priors zero: every kept track has no support.
      program_all(16'd0, 16'd4000, 16'hF000, 16'h1000, 16'd0, 16'd0, 16'd0, 16'd0);
      random_phase(100);
      req_valid <= 1'b0;
      drain();

      // Lower bounds above upper bounds drop every track.
      program_all(16'd3000, 16'd2000, 16'h1000, 16'hF000,
                  16'd32768, 16'd6554, 16'd3277, 16'd1638);
      random_phase(30);
      req_valid <= 1'b0;
      drain();

      // Back to random settings for the remainder.
      program_all(16'($urandom_range(0, 100)), 16'($urandom_range(8000, 65535)),
                  16'(-$urandom_range(4000, 32768)), 16'($urandom_range(4000, 32767)),
                  16'($urandom_range(1, 32768)), 16'($urandom_range(1, 32768)),
                  16'($urandom_range(1, 32768)), 16'($urandom_range(1, 32768)));
      random_phase(220);
      req_valid <= 1'b0;

      end_wait = 0;
      while (pending_pids.size() != 0 && end_wait < STALL_LIMIT) begin
         @(posedge clock);
         end_wait++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_pids.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
